/* src/assert_macros.svh */
// assertion helpers included by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked at every clock edge outside reset
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

/* src/tm_pkg.sv */
package tm_pkg;
    localparam int COORD_BITS_DEF = 16;
    localparam int LENGTH_FRAC_DEF = 8;
    localparam int ANGLE_FRAC_DEF = 16;
    localparam int RADIUS_BITS = 40;
    localparam int ZFRAC = 30;
    localparam int CORDIC_STEPS = 31;
    localparam int ZW = 34;
    localparam logic [ZW-1:0] PI_Q30 = 34'd3373259426;

    typedef enum logic [1:0] {
        ST_VALID      = 2'd0,
        ST_COLLINEAR  = 2'd1,
        ST_COINCIDENT = 2'd2
    } t_status;

    // arctangent table in q30 radians
    function automatic logic [ZW-1:0] atan_q30(input int i);
        logic [ZW-1:0] t;
        case (i)
            0: t = 34'd843314857;
            1: t = 34'd497837829;
            2: t = 34'd263043837;
            3: t = 34'd133525159;
            4: t = 34'd67021687;
            5: t = 34'd33543516;
            6: t = 34'd16775851;
            7: t = 34'd8388437;
            8: t = 34'd4194283;
            9: t = 34'd2097149;
            default: t = ZW'(64'd1 << (30 - i));
        endcase
        return t;
    endfunction
endpackage

/* src/tm_sqrt.sv */
// pipelined restoring square root, one result bit per stage, q format output
module tm_sqrt import tm_pkg::*; #(
    parameter int NBITS = 50,
    parameter int RBITS = 25,
    parameter int TAGW = 1
) (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NBITS-1:0] i_num,
    input  logic [TAGW-1:0]  i_tag,
    output logic [RBITS-1:0] o_root,
    output logic [TAGW-1:0]  o_tag
);
    localparam int RW = 2 * RBITS + 2;

    logic [RW-1:0]    r_rem  [RBITS+1];
    logic [RBITS-1:0] r_root [RBITS+1];
    logic [TAGW-1:0]  r_tag  [RBITS+1];

    always_comb begin
        r_rem[0]  = RW'(i_num);
        r_root[0] = '0;
        r_tag[0]  = i_tag;
    end

    // one bit decided per stage, top bit first
    for (genvar s = 0; s < RBITS; s++) begin : g_st
        localparam int B = RBITS - 1 - s;
        logic [RW-1:0] t;
        assign t = (RW'(r_root[s]) << (B + 1)) + (RW'(1) << (2 * B));
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_tag[s+1] <= r_tag[s];
                if (r_rem[s] >= t) begin
                    r_rem[s+1]  <= r_rem[s] - t;
                    r_root[s+1] <= r_root[s] | (RBITS'(1) << B);
                end else begin
                    r_rem[s+1]  <= r_rem[s];
                    r_root[s+1] <= r_root[s];
                end
            end
        end
    end

    assign o_root = r_root[RBITS];
    assign o_tag  = r_tag[RBITS];
endmodule

/* src/tm_cordic.sv */
// pipelined vectoring cordic, atan2(y, |dot|) folded to [0, pi], q16 rounded
module tm_cordic import tm_pkg::*; #(
    parameter int YBITS = 33,
    parameter int DBITS = 35,
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                       i_clk,
    input  logic                       i_en,
    input  logic [YBITS-1:0]           i_y,
    input  logic signed [DBITS-1:0]    i_dot,
    output logic [ANGLE_FRAC_BITS+1:0] o_angle
);
    localparam int W = 64;
    localparam int NS = CORDIC_STEPS + 2;

    logic signed [W:0]  r_x [NS];
    logic signed [W:0]  r_yy[NS];
    logic signed [ZW:0] r_z [NS];
    logic               r_neg[NS];
    logic               r_zero[NS];
    logic [ANGLE_FRAC_BITS+1:0] r_out;

    logic [W-1:0] xm0, ym0, xn, yn;
    logic [6:0]   lz;

    // stage 0: magnitudes, stage 1: normalize so the larger top bit sits at bit 60
    logic [W-1:0] r_xm, r_ym;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_xm <= i_dot[DBITS-1] ? W'(-i_dot) : W'(i_dot);
            r_ym <= W'(i_y);
            r_neg[0]  <= i_dot[DBITS-1];
            r_zero[0] <= (i_y == '0);
        end
    end

    always_comb begin
        xm0 = r_xm;
        ym0 = r_ym;
        lz = '0;
        for (int k = 0; k < 61; k++) begin
            if ((xm0 | ym0) >= (W'(1) << (60 - k))) lz = lz;
            else lz = 7'(k + 1);
        end
        xn = xm0 << lz;
        yn = ym0 << lz;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[1]    <= $signed({1'b0, xn});
            r_yy[1]   <= $signed({1'b0, yn});
            r_z[1]    <= '0;
            r_neg[1]  <= r_neg[0];
            r_zero[1] <= r_zero[0];
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_rot
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_neg[i+2]  <= r_neg[i+1];
                r_zero[i+2] <= r_zero[i+1];
                if (!r_yy[i+1][W]) begin
                    r_x[i+2]  <= r_x[i+1] + (r_yy[i+1] >>> i);
                    r_yy[i+2] <= r_yy[i+1] - (r_x[i+1] >>> i);
                    r_z[i+2]  <= r_z[i+1] + $signed({1'b0, atan_q30(i)});
                end else begin
                    r_x[i+2]  <= r_x[i+1] - (r_yy[i+1] >>> i);
                    r_yy[i+2] <= r_yy[i+1] + (r_x[i+1] >>> i);
                    r_z[i+2]  <= r_z[i+1] - $signed({1'b0, atan_q30(i)});
                end
            end
        end
    end

    // clamp, fold, round
    logic signed [ZW:0] zc;
    logic [ZW-1:0] zf, zr;
    localparam int SH = ZFRAC - ANGLE_FRAC_BITS;
    always_comb begin
        zc = r_z[NS-1];
        if (zc < 0) zc = '0;
        if (zc > $signed({1'b0, PI_Q30})) zc = $signed({1'b0, PI_Q30});
        if (r_zero[NS-1]) zc = '0;
        zf = r_neg[NS-1] ? PI_Q30 - zc[ZW-1:0] : zc[ZW-1:0];
        zr = (zf + (ZW'(1) << (SH - 1))) >> SH;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_out <= zr[ANGLE_FRAC_BITS+1:0];
    end
    assign o_angle = r_out;
endmodule

/* src/tm_radius.sv */
// circumradius: product of sides then pipelined restoring divide, saturating
module tm_radius import tm_pkg::*; #(
    parameter int SBITS = 25,
    parameter int ABITS = 33,
    parameter int LENGTH_FRAC_BITS = 8
) (
    input  logic               i_clk,
    input  logic               i_en,
    input  logic [SBITS-1:0]   i_sa,
    input  logic [SBITS-1:0]   i_sb,
    input  logic [SBITS-1:0]   i_sc,
    input  logic [ABITS-1:0]   i_area,
    output logic [RADIUS_BITS-1:0] o_radius,
    output logic [1:0]         o_lat_pad
);
    localparam int PW = 3 * SBITS;
    localparam int DW = ABITS + 2 * LENGTH_FRAC_BITS + 1;
    localparam int QB = RADIUS_BITS + 1;

    // stage a: sa*sb, stage b: two half-width partial products with sc
    logic [2*SBITS-1:0] r_ab;
    logic [SBITS-1:0]   r_sc1;
    logic [ABITS-1:0]   r_ar1, r_ar2;
    logic [2*SBITS-1:0] r_plo, r_phi;
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ab  <= i_sa * i_sb;
            r_sc1 <= i_sc;
            r_ar1 <= i_area;
            r_plo <= r_ab[SBITS-1:0] * r_sc1;
            r_phi <= r_ab[2*SBITS-1:SBITS] * r_sc1;
            r_ar2 <= r_ar1;
        end
    end

    // full product of the three sides
    logic [PW-1:0] prod;
    assign prod = {r_phi, SBITS'(0)} + PW'(r_plo);

    // quotient limited to 41 bits, with overflow flagged by high product bits
    logic [DW-1:0]  den;
    assign den = DW'(r_ar2) << (2 * LENGTH_FRAC_BITS + 1);

    logic [PW+DW:0] r_rem [QB+1];
    logic [DW-1:0]  r_den [QB+1];
    logic [QB-1:0]  r_q   [QB+1];
    logic           r_ovf [QB+1];
    logic           r_dz  [QB+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= (PW+DW+1)'(prod);
            r_den[0] <= den;
            r_q[0]   <= '0;
            r_dz[0]  <= (r_ar2 == '0);
            r_ovf[0] <= ((PW+DW+1)'(prod) >> QB) >= (PW+DW+1)'(den);
        end
    end

    for (genvar s = 0; s < QB; s++) begin : g_div
        localparam int B = QB - 1 - s;
        logic [PW+DW:0] t;
        assign t = (PW+DW+1)'(r_den[s]) << B;
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_den[s+1] <= r_den[s];
                r_ovf[s+1] <= r_ovf[s];
                r_dz[s+1]  <= r_dz[s];
                if (!r_ovf[s] && r_rem[s] >= t) begin
                    r_rem[s+1] <= r_rem[s] - t;
                    r_q[s+1]   <= r_q[s] | (QB'(1) << B);
                end else begin
                    r_rem[s+1] <= r_rem[s];
                    r_q[s+1]   <= r_q[s];
                end
            end
        end
    end

    logic sat;
    assign sat = r_ovf[QB] || r_dz[QB] || r_q[QB][QB-1];
    assign o_radius = sat ? '1 : r_q[QB][RADIUS_BITS-1:0];
    assign o_lat_pad = 2'd0;
endmodule

/* src/triangle_measures_top.sv */
// triangle_measures_top: sides, doubled area, circumradius and angles of a triangle
//
// input channel i_valid/o_stall carries the six vertex coordinates; output channel
// o_valid/i_stall carries one result per triangle. a transfer happens on a clock
// edge with valid high and stall low.
// one triangle is taken every cycle while o_stall is low. the whole datapath is
// one pipeline that advances when its output slot is empty or its result is taken;
// it holds LAT = coord + frac + 47 register stages (71 at default parameters). the
// chain: delta/squares (2), square root (one stage per result bit), sides product
// (2), divider load (1), 41-stage divider; the result leaves straight from the last
// divider stage. the angle cordic (with output register) runs alongside, delayed
// to match. when the receiver stalls while the last stage holds an untaken result,
// the pipeline freezes as a whole and o_stall rises, so nothing is lost.
// synchronous active-low reset clears all valid bits; payload is not reset.
module triangle_measures_top import tm_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int LENGTH_FRAC_BITS = LENGTH_FRAC_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic signed [COORD_BITS-1:0] i_ax,
    input  logic signed [COORD_BITS-1:0] i_ay,
    input  logic signed [COORD_BITS-1:0] i_bx,
    input  logic signed [COORD_BITS-1:0] i_by_coord,
    input  logic signed [COORD_BITS-1:0] i_cx,
    input  logic signed [COORD_BITS-1:0] i_cy,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [COORD_BITS+LENGTH_FRAC_BITS:0] o_side_opposite_a,
    output logic [COORD_BITS+LENGTH_FRAC_BITS:0] o_side_opposite_b,
    output logic [COORD_BITS+LENGTH_FRAC_BITS:0] o_side_opposite_c,
    output logic [2*COORD_BITS:0]       o_area_half_units,
    output logic [RADIUS_BITS-1:0]      o_circumradius,
    output logic [ANGLE_FRAC_BITS+1:0]  o_angle_at_a,
    output logic [ANGLE_FRAC_BITS+1:0]  o_angle_at_b,
    output logic [ANGLE_FRAC_BITS+1:0]  o_angle_at_c,
    output logic [1:0]                  o_status
);
`include "assert_macros.svh"
    localparam int DW = COORD_BITS + 1;
    localparam int SQW = 2 * DW + 1;
    localparam int SB = COORD_BITS + 1 + LENGTH_FRAC_BITS;
    localparam int NW = 2 * SB;
    localparam int AB = 2 * COORD_BITS + 1;
    localparam int CW = 2 * DW + 2;
    localparam int RL = SB + 2 + RADIUS_BITS + 2;
    localparam int AL = RL - CORDIC_STEPS - 3;
    localparam int LAT = 2 + RL;
    localparam int AW = ANGLE_FRAC_BITS + 2;

    logic en;
    logic [LAT-1:0] r_vld;
    assign en = !r_vld[LAT-1] || !i_stall;
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    // valid bits march with the data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vld <= '0;
        else if (en) r_vld <= {r_vld[LAT-2:0], i_valid};
    end

    // stage 1: edge vectors
    logic signed [DW-1:0] r_ux, r_uy, r_vx, r_vy, r_wx, r_wy;
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ux <= DW'(i_bx) - DW'(i_ax);
            r_uy <= DW'(i_by_coord) - DW'(i_ay);
            r_vx <= DW'(i_cx) - DW'(i_ax);
            r_vy <= DW'(i_cy) - DW'(i_ay);
            r_wx <= DW'(i_cx) - DW'(i_bx);
            r_wy <= DW'(i_cy) - DW'(i_by_coord);
        end
    end

    // stage 2: squared lengths, cross product and dot products
    logic [SQW-1:0] r_d2a, r_d2b, r_d2c;
    logic [AB-1:0]  r_cross;
    logic signed [CW-1:0] r_da, r_db, r_dc;
    logic signed [CW-1:0] cr;
    assign cr = CW'(r_ux * r_vy) - CW'(r_vx * r_uy);
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_d2a <= SQW'(r_wx * r_wx) + SQW'(r_wy * r_wy);
            r_d2b <= SQW'(r_vx * r_vx) + SQW'(r_vy * r_vy);
            r_d2c <= SQW'(r_ux * r_ux) + SQW'(r_uy * r_uy);
            r_cross <= cr[CW-1] ? AB'(-cr) : AB'(cr);
            r_da <= CW'(r_ux * r_vx) + CW'(r_uy * r_vy);
            r_db <= -(CW'(r_ux * r_wx) + CW'(r_uy * r_wy));
            r_dc <= CW'(r_vx * r_wx) + CW'(r_vy * r_wy);
        end
    end

    logic coinc;
    assign coinc = (r_d2a == '0) || (r_d2b == '0) || (r_d2c == '0);

    // the side a square root carries the area and status flags as tag
    localparam int TW = AB + 2;
    logic [SB-1:0] sa, sb, sc;
    logic [TW-1:0] tag_out, t_unused1, t_unused2;
    tm_sqrt #(.NBITS(NW), .RBITS(SB), .TAGW(TW)) u_sqa (
        .i_clk, .i_en(en),
        .i_num(NW'(r_d2a) << (2 * LENGTH_FRAC_BITS)),
        .i_tag({coinc, r_cross == '0, r_cross}), .o_root(sa), .o_tag(tag_out));
    tm_sqrt #(.NBITS(NW), .RBITS(SB), .TAGW(TW)) u_sqb (
        .i_clk, .i_en(en),
        .i_num(NW'(r_d2b) << (2 * LENGTH_FRAC_BITS)),
        .i_tag(TW'(0)), .o_root(sb), .o_tag(t_unused1));
    tm_sqrt #(.NBITS(NW), .RBITS(SB), .TAGW(TW)) u_sqc (
        .i_clk, .i_en(en),
        .i_num(NW'(r_d2c) << (2 * LENGTH_FRAC_BITS)),
        .i_tag(TW'(0)), .o_root(sc), .o_tag(t_unused2));

    logic [RADIUS_BITS-1:0] rad;
    logic [1:0] pad;
    tm_radius #(.SBITS(SB), .ABITS(AB), .LENGTH_FRAC_BITS(LENGTH_FRAC_BITS)) u_rad (
        .i_clk, .i_en(en), .i_sa(sa), .i_sb(sb), .i_sc(sc),
        .i_area(tag_out[AB-1:0]), .o_radius(rad), .o_lat_pad(pad));

    // delay line matching sides, area and flags to the divider
    localparam int DL = RL - SB;
    logic [3*SB+TW-1:0] r_dly [DL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dly[0] <= {sa, sb, sc, tag_out};
            for (int k = 1; k < DL; k++) r_dly[k] <= r_dly[k-1];
        end
    end

    // angles: cordic plus a matching delay
    logic [AW-1:0] ga, gb, gc;
    tm_cordic #(.YBITS(AB), .DBITS(CW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_ca (
        .i_clk, .i_en(en), .i_y(r_cross), .i_dot(r_da), .o_angle(ga));
    tm_cordic #(.YBITS(AB), .DBITS(CW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cb (
        .i_clk, .i_en(en), .i_y(r_cross), .i_dot(r_db), .o_angle(gb));
    tm_cordic #(.YBITS(AB), .DBITS(CW), .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)) u_cc (
        .i_clk, .i_en(en), .i_y(r_cross), .i_dot(r_dc), .o_angle(gc));

    logic [3*AW-1:0] r_adl [AL];
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_adl[0] <= {ga, gb, gc};
            for (int k = 1; k < AL; k++) r_adl[k] <= r_adl[k-1];
        end
    end

    // output assembly
    logic [3*SB+TW-1:0] fin;
    logic f_coinc, f_col;
    assign fin = r_dly[DL-1];
    assign f_coinc = fin[TW-1];
    assign f_col = fin[TW-2];
    assign o_side_opposite_a = fin[3*SB+TW-1 -: SB];
    assign o_side_opposite_b = fin[2*SB+TW-1 -: SB];
    assign o_side_opposite_c = fin[SB+TW-1 -: SB];
    assign o_area_half_units = fin[AB-1:0];
    assign o_circumradius = (f_coinc || pad != 2'd0) ? '1 : rad;
    assign o_angle_at_a = f_coinc ? '0 : r_adl[AL-1][3*AW-1 -: AW];
    assign o_angle_at_b = f_coinc ? '0 : r_adl[AL-1][2*AW-1 -: AW];
    assign o_angle_at_c = f_coinc ? '0 : r_adl[AL-1][AW-1:0];
    assign o_status = f_coinc ? ST_COINCIDENT : (f_col ? ST_COLLINEAR : ST_VALID);

    `ASSERT_IMPL(a_stall_only_full, i_clk, i_rst_n, o_stall, o_valid && i_stall)
    `ASSERT_IMPL(a_col_sat, i_clk, i_rst_n, o_valid && o_area_half_units == '0,
        o_circumradius == '1)
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_valid && i_stall,
        o_valid && $stable(o_area_half_units))
endmodule

/* sim/triangle_measures_checker.sv */
// watches both channels of triangle_measures_top, predicts each result and compares
module triangle_measures_checker import tm_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall_in,
    input  logic signed [15:0] i_ax,
    input  logic signed [15:0] i_ay,
    input  logic signed [15:0] i_bx,
    input  logic signed [15:0] i_by_coord,
    input  logic signed [15:0] i_cx,
    input  logic signed [15:0] i_cy,
    input  logic               i_out_valid,
    input  logic               i_out_stall,
    input  logic [24:0]        i_side_a,
    input  logic [24:0]        i_side_b,
    input  logic [24:0]        i_side_c,
    input  logic [32:0]        i_area,
    input  logic [39:0]        i_radius,
    input  logic [17:0]        i_ang_a,
    input  logic [17:0]        i_ang_b,
    input  logic [17:0]        i_ang_c,
    input  logic [1:0]         i_status,
    output int                 o_errors,
    output int                 o_pending
);

    typedef struct packed {
        logic [24:0] side_a;
        logic [24:0] side_b;
        logic [24:0] side_c;
        logic [32:0] area;
        logic [39:0] radius;
        logic [17:0] ang_a;
        logic [17:0] ang_b;
        logic [17:0] ang_c;
        t_status     status;
    } measures_t;

    localparam logic [39:0] RADIUS_SAT = '1;
    localparam longint      PI_Z = 64'd3373259426;

    measures_t expected_q[$];

    // arctangent of 2^-i in q30 radians
    function automatic longint atan_step(input int i);
        longint t;
        case (i)
            0: t = 843314857;
            1: t = 497837829;
            2: t = 263043837;
            3: t = 133525159;
            4: t = 67021687;
            5: t = 33543516;
            6: t = 16775851;
            7: t = 8388437;
            8: t = 4194283;
            9: t = 2097149;
            default: t = longint'(1) << (30 - i);
        endcase
        return t;
    endfunction

    // floor square root of a squared distance, scaled to q8
    function automatic logic [24:0] length_q8(input logic [63:0] d2);
        logic [63:0] n;
        logic [31:0] r;
        logic [31:0] t;
        n = d2 << 16;
        r = '0;
        for (int b = 31; b >= 0; b--) begin
            t = r | (32'd1 << b);
            if ({32'd0, t} * {32'd0, t} <= n) r = t;
        end
        return r[24:0];
    endfunction

    // atan2(y, dot) by cordic in q30, rounded to q16
    function automatic logic [17:0] angle_q16(input logic [63:0] y, input longint dot);
        logic [63:0] xm;
        logic [63:0] ym;
        longint x;
        longint yy;
        longint z;
        longint dx;
        longint dy;
        logic [63:0] zr;
        if (y == 0) begin
            z = (dot < 0) ? PI_Z : 0;
        end else begin
            xm = (dot < 0) ? 64'(-dot) : 64'(dot);
            ym = y;
            while ((xm | ym) < (64'd1 << 60)) begin
                xm = xm << 1;
                ym = ym << 1;
            end
            x = longint'(xm);
            yy = longint'(ym);
            z = 0;
            for (int i = 0; i < 31; i++) begin
                dx = yy >>> i;
                dy = x >>> i;
                if (yy >= 0) begin
                    x = x + dx;
                    yy = yy - dy;
                    z = z + atan_step(i);
                end else begin
                    x = x - dx;
                    yy = yy + dy;
                    z = z - atan_step(i);
                end
            end
            if (z < 0) z = 0;
            if (z > PI_Z) z = PI_Z;
            if (dot < 0) z = PI_Z - z;
        end
        zr = (64'(z) + 64'd8192) >> 14;
        return zr[17:0];
    endfunction

    // full set of measures for one triangle
    function automatic measures_t triangle_measures(
        input longint ax, input longint ay, input longint bx,
        input longint by, input longint cx, input longint cy);
        measures_t m;
        longint ux, uy, vx, vy, wx, wy, cr;
        logic [63:0] d2a, d2b, d2c, across;
        logic [127:0] num, den, quo;
        logic coincident;
        ux = bx - ax;
        uy = by - ay;
        vx = cx - ax;
        vy = cy - ay;
        wx = cx - bx;
        wy = cy - by;
        d2a = 64'(wx * wx + wy * wy);
        d2b = 64'(vx * vx + vy * vy);
        d2c = 64'(ux * ux + uy * uy);
        m.side_a = length_q8(d2a);
        m.side_b = length_q8(d2b);
        m.side_c = length_q8(d2c);
        cr = ux * vy - vx * uy;
        across = (cr < 0) ? 64'(-cr) : 64'(cr);
        m.area = across[32:0];
        m.radius = RADIUS_SAT;
        if (across != 0) begin
            num = 128'(m.side_a) * 128'(m.side_b) * 128'(m.side_c);
            den = 128'(across) << 17;
            quo = num / den;
            m.radius = (quo > 128'(RADIUS_SAT)) ? RADIUS_SAT : quo[39:0];
        end
        coincident = (d2a == 0) || (d2b == 0) || (d2c == 0);
        m.status = coincident ? ST_COINCIDENT : ((across == 0) ? ST_COLLINEAR : ST_VALID);
        m.ang_a = '0;
        m.ang_b = '0;
        m.ang_c = '0;
        if (!coincident) begin
            m.ang_a = angle_q16(across, ux * vx + uy * vy);
            m.ang_b = angle_q16(across, (-ux) * wx + (-uy) * wy);
            m.ang_c = angle_q16(across, vx * wx + vy * wy);
        end
        return m;
    endfunction

    // count a bad field, report the first few
    task automatic field_check(input string name, input logic [63:0] exp_v,
                               input logic [63:0] got_v);
        if (exp_v !== got_v) begin
            if (o_errors < 10)
                $display("mismatch %s: expected %0d got %0d", name, exp_v, got_v);
            o_errors++;
        end
    endtask

    // queue expectations on input transfers, compare on output transfers
    always @(posedge i_clk) begin
        measures_t exp_m;
        if (!i_rst_n) begin
            expected_q.delete();
        end else begin
            if (i_valid && !i_stall_in)
                expected_q.push_back(triangle_measures(i_ax, i_ay, i_bx,
                                                       i_by_coord, i_cx, i_cy));
            if (i_out_valid && !i_out_stall) begin
                if (expected_q.size() == 0) begin
                    if (o_errors < 10) $display("unexpected result transfer");
                    o_errors++;
                end else begin
                    exp_m = expected_q.pop_front();
                    field_check("side_opposite_a", 64'(exp_m.side_a), 64'(i_side_a));
                    field_check("side_opposite_b", 64'(exp_m.side_b), 64'(i_side_b));
                    field_check("side_opposite_c", 64'(exp_m.side_c), 64'(i_side_c));
                    field_check("area_half_units", 64'(exp_m.area), 64'(i_area));
                    field_check("circumradius", 64'(exp_m.radius), 64'(i_radius));
                    field_check("angle_at_a", 64'(exp_m.ang_a), 64'(i_ang_a));
                    field_check("angle_at_b", 64'(exp_m.ang_b), 64'(i_ang_b));
                    field_check("angle_at_c", 64'(exp_m.ang_c), 64'(i_ang_c));
                    field_check("status", 64'(exp_m.status), 64'(i_status));
                end
            end
        end
        o_pending = expected_q.size();
    end

    initial begin
        o_errors = 0;
        o_pending = 0;
    end

endmodule

/* sim/tb_triangle_measures_top.sv */
// stimulus and verdict for triangle_measures_top
module tb_triangle_measures_top;
    import tm_pkg::*;

    localparam int LATENCY     = 71;
    localparam int CYCLE_LIMIT = 300000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic i_stall = 1'b0;
    logic signed [15:0] i_ax = '0;
    logic signed [15:0] i_ay = '0;
    logic signed [15:0] i_bx = '0;
    logic signed [15:0] i_by_coord = '0;
    logic signed [15:0] i_cx = '0;
    logic signed [15:0] i_cy = '0;
    logic        o_stall;
    logic        o_valid;
    logic [24:0] o_side_opposite_a;
    logic [24:0] o_side_opposite_b;
    logic [24:0] o_side_opposite_c;
    logic [32:0] o_area_half_units;
    logic [39:0] o_circumradius;
    logic [17:0] o_angle_at_a;
    logic [17:0] o_angle_at_b;
    logic [17:0] o_angle_at_c;
    logic [1:0]  o_status;

    int error_count;
    int pending_count;
    int cycle_count = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    always #5 i_clk = ~i_clk;

    triangle_measures_top u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_stall(o_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy),
        .o_valid(o_valid), .i_stall(i_stall),
        .o_side_opposite_a(o_side_opposite_a), .o_side_opposite_b(o_side_opposite_b),
        .o_side_opposite_c(o_side_opposite_c), .o_area_half_units(o_area_half_units),
        .o_circumradius(o_circumradius), .o_angle_at_a(o_angle_at_a),
        .o_angle_at_b(o_angle_at_b), .o_angle_at_c(o_angle_at_c), .o_status(o_status)
    );

    triangle_measures_checker u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .i_stall_in(o_stall),
        .i_ax(i_ax), .i_ay(i_ay), .i_bx(i_bx), .i_by_coord(i_by_coord),
        .i_cx(i_cx), .i_cy(i_cy),
        .i_out_valid(o_valid), .i_out_stall(i_stall),
        .i_side_a(o_side_opposite_a), .i_side_b(o_side_opposite_b),
        .i_side_c(o_side_opposite_c), .i_area(o_area_half_units),
        .i_radius(o_circumradius), .i_ang_a(o_angle_at_a), .i_ang_b(o_angle_at_b),
        .i_ang_c(o_angle_at_c), .i_status(o_status),
        .o_errors(error_count), .o_pending(pending_count)
    );

    // receiver stalls at random
    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // one triangle transfer, with random idle cycles ahead of it
    task automatic send_triangle(input int ax, input int ay, input int bx,
                                 input int by, input int cx, input int cy);
        while ($urandom_range(99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_ax <= 16'(ax);
        i_ay <= 16'(ay);
        i_bx <= 16'(bx);
        i_by_coord <= 16'(by);
        i_cx <= 16'(cx);
        i_cy <= 16'(cy);
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
    endtask

    function automatic int any_coord();
        return int'($signed(16'($urandom())));
    endfunction

    // random triangle: mostly general, plus tiny, collinear, coincident, extreme
    task automatic send_random();
        int kind;
        int px, py, dx, dy, k1, k2;
        kind = $urandom_range(99);
        if (kind < 55) begin
            send_triangle(any_coord(), any_coord(), any_coord(), any_coord(),
                          any_coord(), any_coord());
        end else if (kind < 70) begin
            send_triangle($urandom_range(16) - 8, $urandom_range(16) - 8,
                          $urandom_range(16) - 8, $urandom_range(16) - 8,
                          $urandom_range(16) - 8, $urandom_range(16) - 8);
        end else if (kind < 82) begin
            px = $urandom_range(2000) - 1000;
            py = $urandom_range(2000) - 1000;
            dx = $urandom_range(400) - 200;
            dy = $urandom_range(400) - 200;
            k1 = $urandom_range(200) - 100;
            k2 = $urandom_range(200) - 100;
            send_triangle(px, py, px + k1 * dx, py + k1 * dy, px + k2 * dx, py + k2 * dy);
        end else if (kind < 90) begin
            px = any_coord();
            py = any_coord();
            case ($urandom_range(2))
                0: send_triangle(px, py, px, py, any_coord(), any_coord());
                1: send_triangle(px, py, any_coord(), any_coord(), px, py);
                default: send_triangle(any_coord(), any_coord(), px, py, px, py);
            endcase
        end else begin
            send_triangle($urandom_range(1) ? 32767 : -32768,
                          $urandom_range(1) ? 32767 : -32768,
                          $urandom_range(1) ? 32767 : -32768,
                          $urandom_range(1) ? 32767 : -32768,
                          any_coord(), $urandom_range(1) ? 32767 : -32768);
        end
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: extremes, degenerate shapes, huge radius
        send_triangle(0, 0, 0, 0, 0, 0);
        send_triangle(-32768, -32768, 32767, 32767, -32768, 32767);
        send_triangle(-32768, -32768, 32767, -32768, 32767, 32767);
        send_triangle(32767, 32767, -32768, -32768, 32767, -32768);
        send_triangle(-32768, 32767, 32767, -32768, -32768, -32768);
        send_triangle(0, 0, 1, 0, 0, 1);
        send_triangle(0, 0, 3, 0, 0, 4);
        send_triangle(0, 0, 1, 0, 2, 0);
        send_triangle(0, 0, 2, 0, 1, 0);
        send_triangle(1, 0, 0, 0, 2, 0);
        send_triangle(-32768, -32768, 0, 0, 32767, 32767);
        send_triangle(-32768, 0, 32767, 0, 0, 1);
        send_triangle(-32768, -32768, 32767, 32767, 32767, 32766);
        send_triangle(5, 5, 5, 5, 9, -3);
        send_triangle(5, 5, 9, -3, 9, -3);
        send_triangle(-1, -1, -1, -1, -1, -1);
        send_triangle(0, 0, 2, 0, 1, 1);
        send_triangle(0, 0, 100, 0, 50, 87);
        send_triangle(-32768, -32768, -32768, -32768, 32767, 32767);

        // random phases with different idle and stall mixes
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 59; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 59; end
                default: begin idle_pct = 11; stall_pct = 11; end
            endcase
            for (int n = 0; n < 285; n++) begin
                // hold off until the pipeline has drained
                if (phase == 1 && n == 140) begin
                    i_valid <= 1'b0;
                    @(posedge i_clk);
                    while (pending_count != 0) @(posedge i_clk);
                end
                send_random();
            end
        end
        i_valid <= 1'b0;
        stall_pct = 0;

        while (pending_count != 0) @(posedge i_clk);
        repeat (LATENCY + 20) @(posedge i_clk);
        if (error_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/tm_pkg.sv
src/tm_sqrt.sv
src/tm_cordic.sv
src/tm_radius.sv
src/triangle_measures_top.sv
sim/triangle_measures_checker.sv
sim/tb_triangle_measures_top.sv
